// File: sv/psdf_pkg.sv
// Package for the per-peer duplicate filter: sizes, codes, payload and job types.
// Used by every module of the block but psdf_ram; depends on nothing.
package psdf_pkg;

  localparam int unsigned MaxPeers = 40;
  localparam int unsigned IdxW     = $clog2(MaxPeers);
  localparam int unsigned CntW     = $clog2(MaxPeers + 1);
  localparam int unsigned SlotW    = 6;
  localparam int unsigned SeqW     = 8;
  localparam int unsigned WinW     = 7;

  localparam logic [SeqW-1:0] NewPeerSeq     = 8'd127;
  localparam logic [WinW-1:0] DupWindowReset = 7'd64;

  typedef enum logic [1:0] {
    StAccept = 2'd0,
    StDup    = 2'd1,
    StNew    = 2'd2,
    StFull   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    JobKnown = 2'd0,
    JobNew   = 2'd1,
    JobFull  = 2'd2
  } job_kind_e;

  typedef enum logic [1:0] {
    FrIdle   = 2'd0,
    FrCmp    = 2'd1,
    FrDecide = 2'd2
  } front_state_e;

  typedef enum logic {
    BkIdle = 1'b0,
    BkRead = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [31:0]     peer_id;
    logic [SeqW-1:0] seq_num;
    logic            channel_a;
    logic            channel_b;
  } in_item_t;

  typedef struct packed {
    logic             duplicate;
    status_e          status;
    logic [SlotW-1:0] peer_slot;
  } out_item_t;

  // Work handed from the lookup front to the sequence back end.
  typedef struct packed {
    job_kind_e       kind;
    logic [CntW-1:0] slot;
    logic [SeqW-1:0] seq_num;
    logic            channel_a;
    logic            channel_b;
  } job_t;

  // One entry of the sequence store: the three channel tracks of a peer.
  typedef struct packed {
    logic [SeqW-1:0] seq_def;
    logic [SeqW-1:0] seq_a;
    logic [SeqW-1:0] seq_b;
  } seq_word_t;

endpackage

// File: sv/psdf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/psdf_front.sv
// Lookup front: accepts packets, matches the peer id table, allocates new slots.
// Depends on psdf_pkg.
module psdf_front import psdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  in_item_t in_item_i,
  output logic     full,
  output logic     job_push_o,
  output job_t     job_o,
  input  logic     job_full_i
);

  front_state_e state_q, state_d;
  in_item_t     item_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [31:0]         id_tbl_q [MaxPeers];
  logic [MaxPeers-1:0] match_q, match_d;
  logic                hit;
  logic [CntW-1:0]     hit_slot;
  logic                accept;
  logic                table_full;
  logic                alloc;

  assign accept     = push && !full;
  assign table_full = (count_q == CntW'(MaxPeers));

  // Compare against every live slot in parallel.
  always_comb begin
    for (int i = 0; i < MaxPeers; i++) begin
      match_d[i] = (id_tbl_q[i] == item_q.peer_id) && (CntW'(i) < count_q);
    end
  end

  // Ids are unique among live slots, so at most one bit is set.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MaxPeers; i++) begin
      hit_slot = hit_slot | (match_q[i] ? CntW'(i) : '0);
    end
  end

  assign hit = |match_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FrIdle: begin
        if (accept) state_d = FrCmp;
      end
      FrCmp:  state_d = FrDecide;
      FrDecide: begin
        if (!job_full_i) state_d = FrIdle;
      end
      default: state_d = FrIdle;
    endcase
  end

  always_comb begin
    full       = 1'b1;
    job_push_o = 1'b0;
    alloc      = 1'b0;
    job_o.seq_num   = item_q.seq_num;
    job_o.channel_a = item_q.channel_a;
    job_o.channel_b = item_q.channel_b;
    job_o.kind      = JobKnown;
    job_o.slot      = hit_slot;
    if (!hit) begin
      if (table_full) begin
        job_o.kind = JobFull;
        job_o.slot = CntW'(MaxPeers);
      end else begin
        job_o.kind = JobNew;
        job_o.slot = count_q;
      end
    end
    unique case (state_q)
      FrIdle:   full = 1'b0;
      FrCmp:    full = 1'b1;
      FrDecide: begin
        job_push_o = !job_full_i;
        alloc      = !job_full_i && !hit && !table_full;
      end
      default:  full = 1'b1;
    endcase
  end

  assign count_d = alloc ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    match_q <= match_d;
    if (alloc) id_tbl_q[count_q[IdxW-1:0]] <= item_q.peer_id;
  end

endmodule

// File: sv/psdf_queue.sv
// Two-entry job queue between the lookup front and the sequence back end.
// Depends on psdf_pkg.
module psdf_queue import psdf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_ptr_q] <= job_i;
  end

endmodule

// File: sv/psdf_back.sv
// Sequence back end: read-modify-write of the per-peer track store, result register.
// Depends on psdf_pkg and psdf_ram.
module psdf_back import psdf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [WinW-1:0] cfg_wdata_i,
  input  job_t            job_i,
  input  logic            job_empty_i,
  output logic            job_pop_o,
  output out_item_t       out_item_o,
  output logic            empty,
  input  logic            pop
);

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [WinW-1:0] win_q;
  out_item_t   out_q, out_d;
  logic        out_valid_q;
  logic        out_load;
  logic        out_free;
  logic        start;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  seq_word_t       ram_wdata, ram_rdata;

  logic [SeqW-1:0]   last_seq;
  logic signed [8:0] diff, win;
  logic              is_dup;
  seq_word_t         upd_word;

  psdf_ram #(
    .Width($bits(seq_word_t)),
    .Depth(MaxPeers)
  ) u_seq_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || pop;
  assign start    = (state_q == BkIdle) && !job_empty_i && out_free;

  always_comb begin
    if (job_q.channel_a)      last_seq = ram_rdata.seq_a;
    else if (job_q.channel_b) last_seq = ram_rdata.seq_b;
    else                      last_seq = ram_rdata.seq_def;
  end

  assign diff   = $signed({1'b0, job_q.seq_num}) - $signed({1'b0, last_seq});
  assign win    = $signed({2'b00, win_q});
  assign is_dup = (diff >= -win) && ((diff <= 9'sd0) || (diff >= win));

  always_comb begin
    upd_word = ram_rdata;
    if (job_q.channel_a)      upd_word.seq_a   = job_q.seq_num;
    else if (job_q.channel_b) upd_word.seq_b   = job_q.seq_num;
    else                      upd_word.seq_def = job_q.seq_num;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (start && job_i.kind == JobKnown) state_d = BkRead;
      end
      BkRead:  state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = job_i.slot[IdxW-1:0];
    ram_waddr = job_i.slot[IdxW-1:0];
    ram_wdata = '{seq_def: NewPeerSeq, seq_a: NewPeerSeq, seq_b: NewPeerSeq};
    unique case (state_q)
      BkIdle: begin
        if (start) begin
          job_pop_o = 1'b1;
          unique case (job_i.kind)
            JobKnown: ram_re = 1'b1;
            JobNew: begin
              ram_we   = 1'b1;
              out_load = 1'b1;
              out_d    = '{duplicate: 1'b0, status: StNew,
                           peer_slot: job_i.slot[SlotW-1:0]};
            end
            JobFull: begin
              out_load = 1'b1;
              out_d    = '{duplicate: 1'b0, status: StFull,
                           peer_slot: SlotW'(MaxPeers)};
            end
            default: job_pop_o = 1'b1;
          endcase
        end
      end
      BkRead: begin
        ram_waddr = job_q.slot[IdxW-1:0];
        ram_wdata = upd_word;
        ram_we    = !is_dup;
        out_load  = 1'b1;
        out_d     = '{duplicate: is_dup, status: is_dup ? StDup : StAccept,
                      peer_slot: job_q.slot[SlotW-1:0]};
      end
      default: job_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
      win_q       <= DupWindowReset;
    end else begin
      state_q <= state_d;
      if (out_load)  out_valid_q <= 1'b1;
      else if (pop)  out_valid_q <= 1'b0;
      if (cfg_we_i)  win_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start)    job_q <= job_i;
    if (out_load) out_q <= out_d;
  end

  assign out_item_o = out_q;
  assign empty      = !out_valid_q;

endmodule

// File: sv/peer_sequence_duplicate_filter_core.sv
// Top level of the per-peer duplicate filter: front, job queue and back end.
// Depends on psdf_pkg, psdf_front, psdf_queue, psdf_back.
//
// Usage:
//   Input channel: drive in_item_i and raise push; the packet is taken at a
//   rising edge where push is high and full is low.
//   Result channel: while empty is low, out_item_o carries the oldest result;
//   it is taken at a rising edge where pop is high.
//   Configuration: pulse cfg_we_i with cfg_wdata_i to set the duplicate
//   window; write it only while the block is idle. Reset value is 64.
// Timing:
//   The front captures a packet, then compares it in parallel against the peer
//   id table, then decides and hands a job to a two-entry queue; it takes no
//   new packet until the job is handed over, and a full queue holds it there.
//   The back end finishes new or full-table packets as it pops them; known
//   peers take a registered read of the sequence RAM, then a write back.
// Reset:
//   Clears the peer count, both state machines, the queue and the result
//   valid; the id table and sequence store keep whatever they held.
// Stall:
//   A result held by the receiver blocks the back end only; the front keeps
//   taking packets until the job queue fills, then holds full high in decide.
module peer_sequence_duplicate_filter_core import psdf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  in_item_t        in_item_i,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output out_item_t       out_item_o,
  input  logic            cfg_we_i,
  input  logic [WinW-1:0] cfg_wdata_i
);

  // Jobs from the front into the queue.
  logic job_push, job_full;
  job_t job_in;
  // Jobs from the queue into the back end.
  logic job_pop, job_empty;
  job_t job_out;

  psdf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item_i),
    .full      (full),
    .job_push_o(job_push),
    .job_o     (job_in),
    .job_full_i(job_full)
  );

  psdf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .job_o  (job_out),
    .empty_o(job_empty)
  );

  psdf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .job_i      (job_out),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .out_item_o (out_item_o),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// File: sv/psdf_checker.sv
// Port-level checker for the duplicate filter top level, with its bind.
// Depends on psdf_pkg and peer_sequence_duplicate_filter_core.
module psdf_checker import psdf_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            empty,
  input logic            pop,
  input out_item_t       out_item_o
);

  // Duplicate flag and status code agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.duplicate == (out_item_o.status == StDup)))
    else $error("duplicate flag disagrees with status");

  // Table full reports the out-of-range slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status == StFull) |-> (out_item_o.peer_slot == SlotW'(MaxPeers)))
    else $error("table full with wrong slot");

  // A new peer always lands in a real slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status == StNew) |-> (32'(out_item_o.peer_slot) < MaxPeers))
    else $error("new peer slot out of range");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind peer_sequence_duplicate_filter_core psdf_checker u_checker (.*);
